// File: rtl/drv_pkg.sv
// Shared constants, payload widths and pipeline sideband types for the
// depth reprojection velocity block. No dependencies.
package drv_pkg;

   // Field widths
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 4;
   localparam int PIX_W     = 12;
   localparam int DEPTH_W   = 17;
   localparam int COEF_W    = 32;
   localparam int VEL_W     = 19;
   localparam int COEF_NUM  = 16;
   localparam int COEF_IDX_W = 4;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 4'd1;
   localparam logic [CFG_W-1:0]     WIDTH_RESET      = 13'd1920;
   localparam logic [CFG_W-1:0]     HEIGHT_RESET     = 13'd1080;
   localparam int                   MAX_FRAME_DIM    = 4096;

   // Item kinds and matrix selects
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_PIXEL     = 1'b1;
   localparam int   MAT_INVERSE  = 0;
   localparam int   MAT_PREVIOUS = 1;

   // Arithmetic
   localparam int FRAC_Q16  = 16;
   localparam int ONE_Q16   = 65536;
   localparam int CU_W      = PIX_W + FRAC_Q16;      // current UV, Q12.16
   localparam int VEC_W     = 31;                    // clip / world vector element
   localparam int ACC_W     = 64;                    // matrix row accumulator
   localparam int NUM_DIV   = 3;
   localparam int VEL_MAX   = 262143;
   localparam int VEL_MIN   = -262144;

   // Pipeline depth
   localparam int UV_STEPS    = CU_W;
   localparam int Q16_STEPS   = 30;
   localparam int SAT_SHIFT   = Q16_STEPS - FRAC_Q16;
   localparam int MAT_STAGES  = 4;
   localparam int PIPE_STAGES = 1 + UV_STEPS + 2 * (1 + MAT_STAGES + Q16_STEPS) + 1;
   localparam int CNT_W       = $clog2(PIPE_STAGES + 1);

   localparam logic [Q16_STEPS-1:0] DIV_LIMIT = '1;  // 2^30 - 1

   typedef struct packed {
      logic                      valid;
      logic signed [DEPTH_W-1:0] depth;
   } uvl_type;

   typedef struct packed {
      logic            valid;
      logic [CU_W-1:0] cu_x;
      logic [CU_W-1:0] cu_y;
      logic            deg;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic [NUM_DIV-1:0] neg;
      logic [NUM_DIV-1:0] sat;
      logic               wz;
   } dside_type;

endpackage

// File: rtl/drv_if.sv
// Valid/ready channel interfaces for pixel/load requests, velocity
// responses and register writes. Depends on drv_pkg.
interface drv_req_if
   import drv_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [PIX_W-1:0]          pixel_x;
   logic [PIX_W-1:0]          pixel_y;
   logic signed [DEPTH_W-1:0] depth_value;
   logic                      matrix_select;
   logic [COEF_IDX_W-1:0]     coef_index;
   logic signed [COEF_W-1:0]  coef_value;

   modport source (output valid, op, pixel_x, pixel_y, depth_value, matrix_select,
                   coef_index, coef_value, input ready);
   modport sink   (input valid, op, pixel_x, pixel_y, depth_value, matrix_select,
                   coef_index, coef_value, output ready);
endinterface

interface drv_rsp_if
   import drv_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] velocity_x;
   logic signed [VEL_W-1:0] velocity_y;
   logic                    degenerate;

   modport source (output valid, velocity_x, velocity_y, degenerate, input ready);
   modport sink   (input valid, velocity_x, velocity_y, degenerate, output ready);
endinterface

interface drv_csr_if
   import drv_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/drv_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; caller guarantees num[QW+DW-1:QW] < den for a valid quotient.
module drv_div_pipe #(
   parameter int DW = 13,
   parameter int QW = 28
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [QW+DW-1:0] num,
   input  logic [DW-1:0]    den,
   output logic [QW-1:0]    quo
);

   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] nlo_ff [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] s_rem;
      logic [DW-1:0] s_den;
      logic [QW-1:0] s_nlo;
      logic [QW-1:0] s_q;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;

      if (i == 0) begin : g_first
         assign s_rem = num[QW+DW-1:QW];
         assign s_den = den;
         assign s_nlo = num[QW-1:0];
         assign s_q   = '0;
      end else begin : g_next
         assign s_rem = rem_ff[i-1];
         assign s_den = den_ff[i-1];
         assign s_nlo = nlo_ff[i-1];
         assign s_q   = q_ff[i-1];
      end

      assign trial = {s_rem, s_nlo[QW-1]};
      assign diff  = trial - {1'b0, s_den};
      assign take  = (trial >= {1'b0, s_den});

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
            den_ff[i] <= s_den;
            nlo_ff[i] <= {s_nlo[QW-2:0], 1'b0};
            q_ff[i]   <= {s_q[QW-2:0], take};
         end
      end
   end

   assign quo = q_ff[QW-1];

endmodule

// File: rtl/depth_reprojection_velocity.sv
// Camera motion vector block: reprojects a pixel through the inverse current
// and the previous view-projection matrices. Depends on drv_pkg, drv_if, drv_div_pipe.
//
// One pixel per clock is accepted unless the pipeline stalls, and its velocity
// reaches the response register through 1 input stage, a 28-step UV
// divider, then two passes of (vector stage, 4 matrix stages, 30-step
// perspective divider), then 1 screen stage. The divider chains make up most
// of that depth; the pipeline itself carries up to 100 pixels. A coefficient
// load is held off (req ready low) until no pixel is in the pipeline, then
// written with no response, so pixels accepted earlier see the old matrices.
// Register writes are taken every cycle. A response waiting in the output
// register only stalls the pipeline when its last stage also holds a pixel.
module depth_reprojection_velocity
   import drv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   drv_req_if.sink    req_chan,
   drv_rsp_if.source  rsp_chan,
   drv_csr_if.sink    csr_chan
);

   // ---------------------------------------------------------------------
   // Configuration and coefficient storage
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]         width_ff;
   logic [CFG_W-1:0]         height_ff;
   logic signed [COEF_W-1:0] mat_ff [2][COEF_NUM];

   // Flow control
   logic             adv;           // whole pipeline moves one stage
   logic             pix_acc;
   logic             load_acc;
   logic [CNT_W-1:0] inflight_ff;   // pixels between input stage and screen stage

   // Input stage
   logic               a_valid_ff;
   logic [PIX_W-1:0]   a_x_ff;
   logic [PIX_W-1:0]   a_y_ff;
   logic signed [DEPTH_W-1:0] a_depth_ff;
   logic [CFG_W-1:0]   a_w_ff;
   logic [CFG_W-1:0]   a_h_ff;

   // UV divider and its sideband
   logic [CU_W-1:0] uvx_quo;
   logic [CU_W-1:0] uvy_quo;
   uvl_type         uvl_ff [UV_STEPS];

   // Matrix passes: pass 0 = inverse current, pass 1 = previous
   logic signed [VEC_W-1:0] mv_in   [2][NUM_DIV];
   logic signed [VEC_W-1:0] mv_ff   [2][NUM_DIV];
   side_type                mvs_in  [2];
   side_type                mvs_ff  [2];
   logic signed [ACC_W-1:0] prod_in [2][4][4];
   logic signed [ACC_W-1:0] prod_ff [2][4][4];
   side_type                s1_ff   [2];
   logic signed [ACC_W-1:0] pair_in [2][4][2];
   logic signed [ACC_W-1:0] pair_ff [2][4][2];
   side_type                s2_ff   [2];
   logic signed [ACC_W-1:0] sum_in  [2][4];
   logic signed [ACC_W-1:0] sum_ff  [2][4];
   side_type                s3_ff   [2];
   logic [ACC_W-1:0]        absn_in [2][NUM_DIV];
   logic [ACC_W-1:0]        absn_ff [2][NUM_DIV];
   logic [ACC_W-1:0]        absd_in [2];
   logic [ACC_W-1:0]        absd_ff [2];
   logic [NUM_DIV-1:0]      neg_in  [2];
   logic [NUM_DIV-1:0]      neg_ff  [2];
   logic                    wz_in   [2];
   logic                    wz_ff   [2];
   side_type                s4_ff   [2];
   logic [NUM_DIV-1:0]      sat_in  [2];
   dside_type               dl_ff   [2][Q16_STEPS];
   logic [Q16_STEPS-1:0]    quo     [2][NUM_DIV];

   // Screen stage
   logic                    s_valid_ff;
   logic [CU_W-1:0]         s_cux_ff;
   logic [CU_W-1:0]         s_cuy_ff;
   logic                    s_deg_ff;
   logic signed [VEC_W-1:0] s_psx_ff;
   logic signed [VEC_W-1:0] s_psy_ff;
   logic signed [VEC_W-1:0] ps_in [2];

   // Response register
   logic                    rsp_valid_ff;
   logic signed [VEL_W-1:0] vx_ff;
   logic signed [VEL_W-1:0] vy_ff;
   logic                    deg_ff;
   logic signed [31:0]      uux;
   logic signed [31:0]      uuy;
   logic signed [31:0]      vdx;
   logic signed [31:0]      vdy;

   // Divisor clamp to [1, MAX_FRAME_DIM]
   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W+1:0] ext;
      ext = {2'b00, v};
      if (v == '0) begin
         return CFG_W'(1);
      end
      if (ext > (CFG_W+2)'(MAX_FRAME_DIM)) begin
         return CFG_W'(MAX_FRAME_DIM);
      end
      return v;
   endfunction

   // Signed Q.16 quotient from magnitude, saturation and sign
   function automatic logic signed [VEC_W-1:0] wn_of(input logic [Q16_STEPS-1:0] q,
                                                     input logic sat, input logic neg);
      logic signed [VEC_W-1:0] mag;
      mag = $signed({1'b0, (sat ? DIV_LIMIT : q)});
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [31:0] v);
      if (v > VEL_MAX) begin
         return VEL_W'(VEL_MAX);
      end
      if (v < VEL_MIN) begin
         return VEL_W'(VEL_MIN);
      end
      return v[VEL_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign adv = !(s_valid_ff && rsp_valid_ff && !rsp_chan.ready);

   // Loads wait for an empty pipeline so in-flight pixels keep old matrices
   assign req_chan.ready = adv && ((req_chan.op == OP_PIXEL) || (inflight_ff == '0));
   assign pix_acc  = req_chan.valid && req_chan.ready && (req_chan.op == OP_PIXEL);
   assign load_acc = req_chan.valid && req_chan.ready && (req_chan.op == OP_LOAD);

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_chan.data;
            CSR_FRAME_HEIGHT: height_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < COEF_NUM; i++) begin
               mat_ff[m][i] <= '0;
            end
         end
      end else if (load_acc) begin
         mat_ff[req_chan.matrix_select][req_chan.coef_index] <= req_chan.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + CNT_W'(pix_acc) - CNT_W'(s_valid_ff && adv);
      end
   end

   // ---------------------------------------------------------------------
   // Current UV: floor(x * 2^16 / width), one quotient bit per stage
   // ---------------------------------------------------------------------
   drv_div_pipe #(.DW(CFG_W), .QW(UV_STEPS)) u_div_uvx (
      .clock  (clock),
      .enable (adv),
      .num    ({{CFG_W{1'b0}}, a_x_ff, {FRAC_Q16{1'b0}}}),
      .den    (a_w_ff),
      .quo    (uvx_quo)
   );

   drv_div_pipe #(.DW(CFG_W), .QW(UV_STEPS)) u_div_uvy (
      .clock  (clock),
      .enable (adv),
      .num    ({{CFG_W{1'b0}}, a_y_ff, {FRAC_Q16{1'b0}}}),
      .den    (a_h_ff),
      .quo    (uvy_quo)
   );

   // ---------------------------------------------------------------------
   // Perspective dividers: |n| * 2^16 / |w|, three in pass 0, two in pass 1
   // ---------------------------------------------------------------------
   for (genvar p = 0; p < 2; p++) begin : g_pass
      for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
         if (p == MAT_INVERSE || k < 2) begin : g_used
            drv_div_pipe #(.DW(ACC_W), .QW(Q16_STEPS)) u_div_q16 (
               .clock  (clock),
               .enable (adv),
               .num    ({{SAT_SHIFT{1'b0}}, absn_ff[p][k], {FRAC_Q16{1'b0}}}),
               .den    (absd_ff[p]),
               .quo    (quo[p][k])
            );
         end else begin : g_unused
            assign quo[p][k] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage logic
   // ---------------------------------------------------------------------
   always_comb begin
      // Clip vector: (2*uv - 1, 2*uv - 1, depth); w = 1.0 is folded in below
      mv_in[0][0] = $signed({2'b00, uvx_quo, 1'b0}) - VEC_W'(ONE_Q16);
      mv_in[0][1] = $signed({2'b00, uvy_quo, 1'b0}) - VEC_W'(ONE_Q16);
      mv_in[0][2] = {{(VEC_W-DEPTH_W){uvl_ff[UV_STEPS-1].depth[DEPTH_W-1]}},
                     uvl_ff[UV_STEPS-1].depth};
      mvs_in[0].valid = uvl_ff[UV_STEPS-1].valid;
      mvs_in[0].cu_x  = uvx_quo;
      mvs_in[0].cu_y  = uvy_quo;
      mvs_in[0].deg   = 1'b0;

      // World position normalized by world w
      for (int k = 0; k < NUM_DIV; k++) begin
         mv_in[1][k] = wn_of(quo[MAT_INVERSE][k], dl_ff[MAT_INVERSE][Q16_STEPS-1].sat[k],
                             dl_ff[MAT_INVERSE][Q16_STEPS-1].neg[k]);
      end
      mvs_in[1]     = dl_ff[MAT_INVERSE][Q16_STEPS-1].side;
      mvs_in[1].deg = dl_ff[MAT_INVERSE][Q16_STEPS-1].wz;

      // Previous screen position, origin when previous w is zero
      for (int k = 0; k < 2; k++) begin
         ps_in[k] = dl_ff[MAT_PREVIOUS][Q16_STEPS-1].wz ? '0 :
                    wn_of(quo[MAT_PREVIOUS][k], dl_ff[MAT_PREVIOUS][Q16_STEPS-1].sat[k],
                          dl_ff[MAT_PREVIOUS][Q16_STEPS-1].neg[k]);
      end

      for (int p = 0; p < 2; p++) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < NUM_DIV; c++) begin
               prod_in[p][r][c] = mat_ff[p][r*4+c] * mv_ff[p][c];
            end
            // Fourth element is 1.0: a shift, no multiplier
            prod_in[p][r][3] = {{(ACC_W-COEF_W-FRAC_Q16){mat_ff[p][r*4+3][COEF_W-1]}},
                                mat_ff[p][r*4+3], {FRAC_Q16{1'b0}}};
            pair_in[p][r][0] = prod_ff[p][r][0] + prod_ff[p][r][1];
            pair_in[p][r][1] = prod_ff[p][r][2] + prod_ff[p][r][3];
            sum_in[p][r]     = pair_ff[p][r][0] + pair_ff[p][r][1];
         end
         for (int k = 0; k < NUM_DIV; k++) begin
            absn_in[p][k] = sum_ff[p][k][ACC_W-1] ? -sum_ff[p][k] : sum_ff[p][k];
            neg_in[p][k]  = sum_ff[p][k][ACC_W-1] ^ sum_ff[p][3][ACC_W-1];
            // Quotient would reach 2^30: clamp
            sat_in[p][k]  = (absn_ff[p][k] >> SAT_SHIFT) >= absd_ff[p];
         end
         absd_in[p] = sum_ff[p][3][ACC_W-1] ? -sum_ff[p][3] : sum_ff[p][3];
         wz_in[p]   = (sum_ff[p][3] == '0);
      end
   end

   // Valid and sideband path (reset)
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         for (int i = 0; i < UV_STEPS; i++) begin
            uvl_ff[i] <= '0;
         end
         for (int p = 0; p < 2; p++) begin
            mvs_ff[p] <= '0;
            s1_ff[p]  <= '0;
            s2_ff[p]  <= '0;
            s3_ff[p]  <= '0;
            s4_ff[p]  <= '0;
            for (int i = 0; i < Q16_STEPS; i++) begin
               dl_ff[p][i] <= '0;
            end
         end
      end else if (adv) begin
         a_valid_ff <= pix_acc;
         uvl_ff[0]  <= '{valid: a_valid_ff, depth: a_depth_ff};
         for (int i = 1; i < UV_STEPS; i++) begin
            uvl_ff[i] <= uvl_ff[i-1];
         end
         for (int p = 0; p < 2; p++) begin
            mvs_ff[p] <= mvs_in[p];
            s1_ff[p]  <= mvs_ff[p];
            s2_ff[p]  <= s1_ff[p];
            s3_ff[p]  <= s2_ff[p];
            s4_ff[p]  <= s3_ff[p];
            dl_ff[p][0] <= '{side: s4_ff[p], neg: neg_ff[p], sat: sat_in[p], wz: wz_ff[p]};
            for (int i = 1; i < Q16_STEPS; i++) begin
               dl_ff[p][i] <= dl_ff[p][i-1];
            end
         end
         s_valid_ff <= dl_ff[MAT_PREVIOUS][Q16_STEPS-1].side.valid;
      end
   end

   // Datapath (no reset)
   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff     <= req_chan.pixel_x;
         a_y_ff     <= req_chan.pixel_y;
         a_depth_ff <= req_chan.depth_value;
         a_w_ff     <= eff_dim(width_ff);
         a_h_ff     <= eff_dim(height_ff);
         mv_ff      <= mv_in;
         prod_ff    <= prod_in;
         pair_ff    <= pair_in;
         sum_ff     <= sum_in;
         absn_ff    <= absn_in;
         absd_ff    <= absd_in;
         neg_ff     <= neg_in;
         wz_ff      <= wz_in;
         s_cux_ff   <= dl_ff[MAT_PREVIOUS][Q16_STEPS-1].side.cu_x;
         s_cuy_ff   <= dl_ff[MAT_PREVIOUS][Q16_STEPS-1].side.cu_y;
         s_deg_ff   <= dl_ff[MAT_PREVIOUS][Q16_STEPS-1].side.deg;
         s_psx_ff   <= ps_in[0];
         s_psy_ff   <= ps_in[1];
      end
   end

   // ---------------------------------------------------------------------
   // Previous UV = floor((screen + 1.0) / 2); velocity = current - previous
   // ---------------------------------------------------------------------
   always_comb begin
      uux = (32'(s_psx_ff) + 32'(ONE_Q16)) >>> 1;
      uuy = (32'(s_psy_ff) + 32'(ONE_Q16)) >>> 1;
      vdx = $signed({4'b0000, s_cux_ff}) - uux;
      vdy = $signed({4'b0000, s_cuy_ff}) - uuy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s_valid_ff) begin
         // Degenerate world w: both components pinned high
         vx_ff  <= s_deg_ff ? VEL_W'(VEL_MAX) : sat_vel(vdx);
         vy_ff  <= s_deg_ff ? VEL_W'(VEL_MAX) : sat_vel(vdy);
         deg_ff <= s_deg_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.velocity_x = vx_ff;
   assign rsp_chan.velocity_y = vy_ff;
   assign rsp_chan.degenerate = deg_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_STAGES))
      else $error("in-flight pixel count beyond pipeline depth");

   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == '0) |-> !s_valid_ff)
      else $error("screen stage holds a pixel the counter does not know");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s_valid_ff && adv))
      else $error("response raised without a pixel leaving the pipeline");

endmodule

// File: dv/depth_reprojection_velocity_tb.sv
// Self-checking testbench for depth_reprojection_velocity: drives pixel,
// coefficient and register transfers, predicts velocities and compares every response.
// Depends on drv_pkg, drv_if and the block itself.
`timescale 1ns / 100ps

module depth_reprojection_velocity_tb
   import drv_pkg::*;
();

   localparam longint CYCLE_LIMIT = 1500000;
   localparam int     DRAIN_WAIT  = PIPE_STAGES + 20;
   localparam longint Q30_MAX     = (64'd1 << 30) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd15;

   // one pending request; drain_mark makes the sender wait for all results
   typedef struct {
      bit                        drain_mark;
      logic                      op;
      logic [PIX_W-1:0]          px;
      logic [PIX_W-1:0]          py;
      logic signed [DEPTH_W-1:0] depth;
      logic                      msel;
      logic [COEF_IDX_W-1:0]     idx;
      logic signed [COEF_W-1:0]  coef;
   } req_item_type;

   typedef struct {
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
      logic                    deg;
   } velocity_type;

   logic clock;
   logic reset;

   drv_req_if req ();
   drv_rsp_if rsp ();
   drv_csr_if csr ();

   depth_reprojection_velocity uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req.sink),
      .rsp_chan (rsp.source),
      .csr_chan (csr.sink)
   );

   // predictor state: our own copy of both matrices and the frame size
   logic signed [COEF_W-1:0] inv_vp[COEF_NUM];
   logic signed [COEF_W-1:0] prev_vp[COEF_NUM];
   logic [CFG_W-1:0]         frame_w;
   logic [CFG_W-1:0]         frame_h;

   req_item_type pending_reqs[$];
   velocity_type expected_vel[$];

   int     errors;
   longint cycles;
   bit     req_took, csr_took;
   bit     hold_go;
   int     cur_w, cur_h;   // frame size used by the stimulus generator

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint dim_clamp(logic [CFG_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_FRAME_DIM) return MAX_FRAME_DIM;
      return longint'(v);
   endfunction

   // Q.16 quotient, truncated toward zero, magnitude capped at 2^30-1
   function automatic longint q16_quotient(longint num, longint den);
      bit                neg;
      longint unsigned   n, d, q, r;
      neg = (num < 0) != (den < 0);
      n   = (num < 0) ? longint'(-num) : num;
      d   = (den < 0) ? longint'(-den) : den;
      q   = n / d;
      if (q > (Q30_MAX >> 16)) begin
         q = Q30_MAX;
      end else begin
         r = n - q * d;
         for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
               r = r - d;
               q = q | 1;
            end
         end
         if (q > Q30_MAX) q = Q30_MAX;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [VEL_W-1:0] vel_clamp(longint v);
      if (v > VEL_MAX) v = VEL_MAX;
      if (v < VEL_MIN) v = VEL_MIN;
      return v[VEL_W-1:0];
   endfunction

   function automatic velocity_type predict_velocity(logic [PIX_W-1:0] px,
                                                     logic [PIX_W-1:0] py,
                                                     logic signed [DEPTH_W-1:0] depth);
      velocity_type res;
      longint       cu_x, cu_y, sx, sy;
      longint       clip[4], world[4], wn[4], prj[4];
      cu_x    = (longint'(px) << 16) / dim_clamp(frame_w);
      cu_y    = (longint'(py) << 16) / dim_clamp(frame_h);
      clip[0] = 2 * cu_x - ONE_Q16;
      clip[1] = 2 * cu_y - ONE_Q16;
      clip[2] = depth;
      clip[3] = ONE_Q16;
      // 64-bit row sums wrap exactly like the hardware accumulator
      for (int r = 0; r < 4; r++) begin
         world[r] = 0;
         for (int c = 0; c < 4; c++) world[r] += longint'(inv_vp[r*4+c]) * clip[c];
      end
      if (world[3] == 0) begin
         res.vx  = VEL_W'(VEL_MAX);
         res.vy  = VEL_W'(VEL_MAX);
         res.deg = 1'b1;
         return res;
      end
      for (int r = 0; r < 3; r++) wn[r] = q16_quotient(world[r], world[3]);
      wn[3] = ONE_Q16;
      for (int r = 0; r < 4; r++) begin
         prj[r] = 0;
         for (int c = 0; c < 4; c++) prj[r] += longint'(prev_vp[r*4+c]) * wn[c];
      end
      sx = 0;
      sy = 0;
      if (prj[3] != 0) begin
         sx = q16_quotient(prj[0], prj[3]);
         sy = q16_quotient(prj[1], prj[3]);
      end
      // previous UV = floor((screen + 1.0) / 2)
      res.vx  = vel_clamp(cu_x - ((sx + ONE_Q16) >>> 1));
      res.vy  = vel_clamp(cu_y - ((sy + ONE_Q16) >>> 1));
      res.deg = 1'b0;
      return res;
   endfunction

   // ------------------------------------------------------- stimulus builders
   function automatic void push_load(int msel, int idx, logic signed [COEF_W-1:0] val);
      req_item_type it;
      it            = '{default: '0};
      it.op         = OP_LOAD;
      it.msel       = 1'(msel);
      it.idx        = COEF_IDX_W'(idx);
      it.coef       = val;
      // fields a load ignores still get random values
      it.px         = PIX_W'($urandom);
      it.py         = PIX_W'($urandom);
      it.depth      = DEPTH_W'($urandom);
      pending_reqs.push_back(it);
   endfunction

   function automatic void push_pixel(int px, int py, logic signed [DEPTH_W-1:0] depth);
      req_item_type it;
      it       = '{default: '0};
      it.op    = OP_PIXEL;
      it.px    = PIX_W'(px);
      it.py    = PIX_W'(py);
      it.depth = depth;
      it.msel  = 1'($urandom);
      it.idx   = COEF_IDX_W'($urandom);
      it.coef  = $urandom;
      pending_reqs.push_back(it);
   endfunction

   function automatic void push_drain();
      req_item_type it;
      it            = '{default: '0};
      it.drain_mark = 1'b1;
      pending_reqs.push_back(it);
   endfunction

   function automatic logic signed [COEF_W-1:0] near_val(int base, int spread);
      return base + $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // plausible camera: near-identity with small perturbations, w row ~(0,0,0,1)
   function automatic void load_camera(int msel, bit zero_w);
      for (int i = 0; i < COEF_NUM; i++) begin
         if (i >= 12 && zero_w)
            push_load(msel, i, 0);
         else if (i == 15 || i % 5 == 0)
            push_load(msel, i, near_val(ONE_Q16, 8192));
         else
            push_load(msel, i, near_val(0, (i >= 12) ? 512 : 6000));
      end
   endfunction

   function automatic void load_identity(int msel);
      for (int i = 0; i < COEF_NUM; i++) push_load(msel, i, (i % 5 == 0) ? ONE_Q16 : 0);
   endfunction

   function automatic logic signed [DEPTH_W-1:0] rand_depth();
      if ($urandom_range(0, 1)) return DEPTH_W'($urandom);
      return DEPTH_W'(near_val(0, 40000));
   endfunction

   function automatic void add_random_items(int n);
      int k, r, xl, yl;
      k = 0;
      while (k < n) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            load_camera(MAT_INVERSE, $urandom_range(0, 9) == 0);
            load_camera(MAT_PREVIOUS, $urandom_range(0, 7) == 0);
            k += 2 * COEF_NUM;
         end else if (r < 7) begin
            push_load(int'($urandom_range(0, 1)), int'($urandom_range(0, 15)),
                      $urandom);   // noise coefficient
            k++;
         end else begin
            xl = (cur_w > 0 && cur_w <= 4096) ? cur_w - 1 : 4095;
            yl = (cur_h > 0 && cur_h <= 4096) ? cur_h - 1 : 4095;
            if ($urandom_range(0, 7) == 0) begin
               push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), rand_depth());
            end else begin
               push_pixel($urandom_range(0, xl), $urandom_range(0, yl), rand_depth());
            end
            k++;
         end
      end
   endfunction

   // ------------------------------------------------------------ sequencing
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || expected_vel.size() != 0 || (req.valid && !req_took))
         @(posedge clock);
      // a load still in flight gives no response, so give the pipe time
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= CFG_W'(val);
      do @(negedge clock); while (!csr_took);
      csr.valid <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cur_w = val;
      if (idx == CSR_FRAME_HEIGHT) cur_h = val;
   endtask

   task automatic set_frame(int w, int h);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
   endtask

   // ------------------------------------------------------------- driver
   int burst_left, gap_left;

   always @(negedge clock) begin
      req_item_type it;
      if (!reset && (!req.valid || req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req.valid <= 1'b0;
         end else if (pending_reqs[0].drain_mark) begin
            // sender pause: nothing new until every response is back
            if (expected_vel.size() == 0) void'(pending_reqs.pop_front());
            req.valid <= 1'b0;
         end else begin
            it = pending_reqs.pop_front();
            req.valid         <= 1'b1;
            req.op            <= it.op;
            req.pixel_x       <= it.px;
            req.pixel_y       <= it.py;
            req.depth_value   <= it.depth;
            req.matrix_select <= it.msel;
            req.coef_index    <= it.idx;
            req.coef_value    <= it.coef;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            end
            burst_left--;
         end
      end
   end

   // ------------------------------------------------------------- receiver
   int hold_cnt, stall_mode, mode_left;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_go) begin
            hold_go  = 1'b0;
            hold_cnt = 3 * PIPE_STAGES;
         end
         if (mode_left <= 0) begin
            mode_left  = $urandom_range(16, 120);
            stall_mode = $urandom_range(0, 2);
         end
         mode_left--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp.ready <= 1'b1;
               1:       rsp.ready <= 1'($urandom_range(0, 1));
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------- monitor
   always @(posedge clock) begin
      velocity_type exp_v;
      cycles   <= cycles + 1;
      req_took <= req.valid && req.ready;
      csr_took <= csr.valid && csr.ready;
      if (reset) begin
         frame_w <= WIDTH_RESET;
         frame_h <= HEIGHT_RESET;
         for (int i = 0; i < COEF_NUM; i++) begin
            inv_vp[i]  <= '0;
            prev_vp[i] <= '0;
         end
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_FRAME_WIDTH) frame_w <= csr.data;
            if (csr.index == CSR_FRAME_HEIGHT) frame_h <= csr.data;
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_PIXEL)
               expected_vel.push_back(predict_velocity(req.pixel_x, req.pixel_y,
                                                       req.depth_value));
            else if (req.matrix_select == MAT_PREVIOUS)
               prev_vp[req.coef_index] <= req.coef_value;
            else
               inv_vp[req.coef_index] <= req.coef_value;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_vel.size() == 0) begin
               $error("response transfer with no pending pixel");
               errors++;
            end else begin
               exp_v = expected_vel.pop_front();
               if (rsp.velocity_x !== exp_v.vx) begin
                  $error("velocity_x: expected %0d, got %0d", exp_v.vx, rsp.velocity_x);
                  errors++;
               end
               if (rsp.velocity_y !== exp_v.vy) begin
                  $error("velocity_y: expected %0d, got %0d", exp_v.vy, rsp.velocity_y);
                  errors++;
               end
               if (rsp.degenerate !== exp_v.deg) begin
                  $error("degenerate: expected %0d, got %0d", exp_v.deg, rsp.degenerate);
                  errors++;
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- main flow
   initial begin
      errors = 0;
      cycles = 0;
      cur_w  = WIDTH_RESET;
      cur_h  = HEIGHT_RESET;
      req.valid = 1'b0;  req.op = OP_LOAD;  req.pixel_x = '0;  req.pixel_y = '0;
      req.depth_value = '0;  req.matrix_select = 1'b0;  req.coef_index = '0;
      req.coef_value = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;  csr.index = '0;  csr.data = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero matrices after reset give a zero world w -> degenerate
      push_pixel(100, 50, 0);
      load_identity(MAT_INVERSE);
      load_identity(MAT_PREVIOUS);
      push_pixel(0, 0, -65536);
      push_pixel(4095, 4095, 65535);   // outside the default frame
      push_pixel(1919, 1079, 0);
      push_pixel(960, 540, 32768);
      // previous w row zeroed -> previous screen taken as origin
      for (int i = 12; i < 16; i++) push_load(MAT_PREVIOUS, i, 0);
      push_pixel(300, 700, -1);
      // extreme coefficients exercise the divider caps
      push_load(MAT_INVERSE, 0, 32'sh7fffffff);
      push_load(MAT_INVERSE, 15, 1);
      push_load(MAT_PREVIOUS, 15, 32'sh80000000);
      push_pixel(4095, 0, 65535);
      push_pixel(0, 4095, -65536);

      // frame size extremes, including out-of-range register values
      set_frame(1, 4096);
      push_pixel(0, 4095, 1000);
      push_pixel(4095, 0, -1000);
      set_frame(0, 8191);
      push_pixel(4095, 4095, 65535);
      push_pixel(1, 1, 0);
      wait_idle();
      csr_write(CSR_UNMAPPED, 13'h1555);   // unmapped index, ignored

      set_frame(4096, 1);
      load_camera(MAT_INVERSE, 0);
      load_camera(MAT_PREVIOUS, 0);
      add_random_items(250);
      push_drain();
      add_random_items(100);

      set_frame(640, 480);
      add_random_items(300);

      // long receiver hold while the sender keeps offering pixels
      set_frame(1920, 1080);
      hold_go = 1'b1;
      for (int i = 0; i < 260; i++) push_pixel($urandom_range(0, 1919),
                                                $urandom_range(0, 1079), rand_depth());
      add_random_items(100);

      set_frame($urandom_range(1, 8191), $urandom_range(1, 8191));
      add_random_items(200);
      push_drain();
      add_random_items(100);

      set_frame($urandom_range(16, 300), $urandom_range(16, 300));
      add_random_items(300);

      wait_idle();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/drv_pkg.sv
rtl/drv_if.sv
rtl/drv_div_pipe.sv
rtl/depth_reprojection_velocity.sv
dv/depth_reprojection_velocity_tb.sv
